FILE: design/grs_pkg.sv
package grs_pkg;

    localparam int NUM_RF = 8;
    localparam int NUM_PGA = 5;
    localparam int LOG_STEPS = 16;

    localparam int LOG_LAT = LOG_STEPS + 1;
    localparam int EXP_LAT = LOG_STEPS + 6;
    localparam int SEL_LAT = 3;
    localparam int TOTAL_LAT = LOG_LAT + EXP_LAT + SEL_LAT;

    localparam logic [27:0] TARGET_MAX = 28'hFFFFFFF;
    localparam logic [27:0] ERR_LIMIT = 28'd16000000;
    localparam logic [31:0] REF_FREQ = 32'd1000;

    localparam logic CFG_CG_MAX = 1'b0;
    localparam logic CFG_CG_MIN = 1'b1;

    localparam logic [17:0] RF_OHMS [NUM_RF] = '{
        18'd200, 18'd1000, 18'd5000, 18'd10000,
        18'd20000, 18'd40000, 18'd80000, 18'd160000
    };
    localparam logic [4:0] PGA_HALVES [NUM_PGA] = '{5'd2, 5'd3, 5'd4, 5'd8, 5'd18};

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_NORM,
        SEQ_SQ
    } seq_state_t;

    typedef struct packed {
        logic [4:0]  n;
        logic [30:0] m;
    } norm_t;

    typedef struct packed {
        logic        hi;
        logic [30:0] m;
    } sq_t;

    typedef struct packed {
        logic signed [21:0] d;
        logic [20:0]        lmax;
        logic signed [21:0] offs;
    } cfg_log_t;

    typedef logic [LOG_STEPS-1:0][31:0] ctab_t;

    // Leading-one search and normalization of a word to Q1.30.
    function automatic norm_t log_norm(input logic [31:0] x);
        logic [31:0] v;
        logic [4:0]  n;
        norm_t       r;
        v = (x == 32'd0) ? 32'd1 : x;
        n = 5'd0;
        for (int b = 0; b < 32; b++)
        begin
            if (v[b])
            begin
                n = 5'(b);
            end
        end
        if (n == 5'd31)
        begin
            r.m = v[31:1];
        end
        else
        begin
            r.m = 31'(v << (5'd30 - n));
        end
        r.n = n;
        return r;
    endfunction

    // One squaring step of the bitwise logarithm.
    function automatic sq_t log_sq(input logic [30:0] m);
        logic [61:0] p;
        logic [31:0] s;
        sq_t         r;
        p = 62'(m) * 62'(m);
        s = p[61:30];
        r.hi = s[31];
        r.m = s[31] ? s[31:1] : s[30:0];
        return r;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v = v_in;
        res = 64'd0;
        bt = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= res + bt)
            begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // Roots 2^(2^-k) in Q1.30, entry k-1 for k = 1..16.
    function automatic ctab_t make_ctab();
        logic [63:0] c;
        ctab_t       t;
        c = 64'd1 << 31;
        for (int k = 0; k < LOG_STEPS; k++)
        begin
            c = isqrt64(c << 30);
            t[k] = c[31:0];
        end
        return t;
    endfunction

    localparam ctab_t C_TAB = make_ctab();

    function automatic logic [21:0] grs_prod(input logic [2:0] i, input logic [2:0] j);
        return 22'(RF_OHMS[i]) * 22'(PGA_HALVES[j]);
    endfunction

endpackage

FILE: design/grs_cfg_log.sv
module grs_cfg_log
    import grs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        busy,
    output cfg_log_t    cfg_log
);

    seq_state_t  state_reg, state_next;
    logic [1:0]  sel_reg, sel_next;
    logic [3:0]  step_reg, step_next;
    logic [4:0]  n_reg, n_next;
    logic [30:0] m_reg, m_next;
    logic [15:0] frac_reg, frac_next;
    logic [31:0] cg_max_reg, cg_max_next;
    logic [31:0] cg_min_reg, cg_min_next;
    logic [20:0] l_ref_reg, l_ref_next;
    logic [20:0] l_max_reg, l_max_next;
    logic [20:0] l_min_reg, l_min_next;
    logic [31:0] operand;
    logic [20:0] result;
    norm_t       nrm;
    sq_t         sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_NORM;
            sel_reg    <= 2'd0;
            step_reg   <= 4'd0;
            cg_max_reg <= 32'd160000;
            cg_min_reg <= 32'd200;
        end
        else
        begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            step_reg   <= step_next;
            cg_max_reg <= cg_max_next;
            cg_min_reg <= cg_min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        m_reg     <= m_next;
        frac_reg  <= frac_next;
        l_ref_reg <= l_ref_next;
        l_max_reg <= l_max_next;
        l_min_reg <= l_min_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        step_next   = step_reg;
        n_next      = n_reg;
        m_next      = m_reg;
        frac_next   = frac_reg;
        cg_max_next = cg_max_reg;
        cg_min_next = cg_min_reg;
        l_ref_next  = l_ref_reg;
        l_max_next  = l_max_reg;
        l_min_next  = l_min_reg;

        case (sel_reg)
            2'd0:    operand = REF_FREQ;
            2'd1:    operand = cg_max_reg;
            default: operand = cg_min_reg;
        endcase
        nrm = log_norm(operand);
        sq = log_sq(m_reg);
        result = {n_reg, frac_reg[14:0], sq.hi};

        unique case (state_reg)
            SEQ_IDLE:
            begin
            end
            SEQ_NORM:
            begin
                n_next = nrm.n;
                m_next = nrm.m;
                frac_next = 16'd0;
                step_next = 4'd0;
                state_next = SEQ_SQ;
            end
            SEQ_SQ:
            begin
                m_next = sq.m;
                frac_next = {frac_reg[14:0], sq.hi};
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    case (sel_reg)
                        2'd0:    l_ref_next = result;
                        2'd1:    l_max_next = result;
                        default: l_min_next = result;
                    endcase
                    if (sel_reg == 2'd2)
                    begin
                        state_next = SEQ_IDLE;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                        state_next = SEQ_NORM;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CG_MAX: cg_max_next = cfg_data;
                CFG_CG_MIN: cg_min_next = cfg_data;
                default:    cg_max_next = cg_max_reg;
            endcase
            state_next = SEQ_NORM;
            sel_next = 2'd0;
        end
    end

    assign busy = (state_reg != SEQ_IDLE);
    assign cfg_log.d = $signed({1'b0, l_min_reg}) - $signed({1'b0, l_max_reg});
    assign cfg_log.lmax = l_max_reg;
    assign cfg_log.offs = 22'sd65536 - $signed({1'b0, l_ref_reg});

endmodule

FILE: design/grs_log_pipe.sv
module grs_log_pipe
    import grs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [26:0] freq_mhz,
    output logic        out_valid,
    output logic [20:0] lf
);

    logic        v_reg [LOG_STEPS+1];
    logic [30:0] m_reg [LOG_STEPS+1];
    logic [4:0]  n_reg [LOG_STEPS+1];
    logic [15:0] f_reg [LOG_STEPS+1];
    norm_t       nrm;

    assign nrm = log_norm({5'd0, freq_mhz});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg[0] <= nrm.m;
        n_reg[0] <= nrm.n;
        f_reg[0] <= 16'd0;
    end

    for (genvar k = 1; k <= LOG_STEPS; k++)
    begin : g_step
        sq_t sq;
        assign sq = log_sq(m_reg[k-1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            m_reg[k] <= sq.m;
            n_reg[k] <= n_reg[k-1];
            f_reg[k] <= {f_reg[k-1][14:0], sq.hi};
        end
    end

    assign out_valid = v_reg[LOG_STEPS];
    assign lf = {n_reg[LOG_STEPS], f_reg[LOG_STEPS]};

endmodule

FILE: design/grs_exp_pipe.sv
module grs_exp_pipe
    import grs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [20:0] lf,
    input  cfg_log_t    cfg_log,
    output logic        out_valid,
    output logic [27:0] target
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [22:0] t_reg;
    logic signed [45:0] p_reg;
    logic [28:0]        x_reg;
    logic               s3_reg, s4_reg;
    logic [27:0]        qa_reg;
    logic               vm_reg [LOG_STEPS+1];
    logic [31:0]        mm_reg [LOG_STEPS+1];
    logic [15:0]        fr_reg [LOG_STEPS+1];
    logic signed [13:0] ip_reg [LOG_STEPS+1];
    logic               vo_reg;
    logic [27:0]        tgt_reg, tgt_next;

    logic signed [21:0] d_s;
    logic signed [21:0] offs_s;
    logic [45:0]        mag;
    logic [45:0]        rnd;
    logic [60:0]        y;
    logic signed [28:0] q;
    logic signed [29:0] logcg;
    logic signed [13:0] ip_last;
    logic signed [13:0] rr;
    logic [4:0]         r;
    logic [32:0]        sum;

    assign d_s = cfg_log.d;
    assign offs_s = cfg_log.offs;
    assign mag = p_reg[45] ? 46'(-p_reg) : 46'(p_reg);
    assign rnd = mag + 46'd196608;
    assign y = 61'(x_reg) * 61'(32'hAAAAAAAB);
    assign q = s4_reg ? -$signed({1'b0, qa_reg}) : $signed({1'b0, qa_reg});
    assign logcg = $signed({9'd0, cfg_log.lmax}) + 30'(q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vm_reg[0] <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vm_reg[0] <= v4_reg;
            vo_reg <= vm_reg[LOG_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= $signed({2'b00, lf}) + 23'(offs_s);
        p_reg <= 46'(d_s) * 46'(t_reg);
        x_reg <= rnd[45:17];
        s3_reg <= p_reg[45];
        qa_reg <= y[60:33];
        s4_reg <= s3_reg;
        mm_reg[0] <= 32'h40000000;
        fr_reg[0] <= logcg[15:0];
        ip_reg[0] <= logcg[29:16];
        tgt_reg <= tgt_next;
    end

    for (genvar k = 1; k <= LOG_STEPS; k++)
    begin : g_mul
        logic [63:0] prod;
        assign prod = 64'(mm_reg[k-1]) * 64'(C_TAB[k-1]) + 64'h20000000;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vm_reg[k] <= 1'b0;
            end
            else
            begin
                vm_reg[k] <= vm_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            mm_reg[k] <= fr_reg[k-1][LOG_STEPS-k] ? prod[61:30] : mm_reg[k-1];
            fr_reg[k] <= fr_reg[k-1];
            ip_reg[k] <= ip_reg[k-1];
        end
    end

    always_comb
    begin
        ip_last = ip_reg[LOG_STEPS];
        rr = 14'sd26 - ip_last;
        r = rr[4:0];
        sum = 33'(mm_reg[LOG_STEPS]) + (33'd1 << (r - 5'd1));
        if (ip_last >= 14'sd24)
        begin
            tgt_next = TARGET_MAX;
        end
        else if (ip_last < -14'sd5)
        begin
            tgt_next = 28'd0;
        end
        else
        begin
            tgt_next = 28'(sum >> r);
        end
    end

    assign out_valid = vo_reg;
    assign target = tgt_reg;

endmodule

FILE: design/grs_select.sv
module grs_select
    import grs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [27:0] target,
    output logic        done,
    output logic [2:0]  rf_index,
    output logic [2:0]  pga_index,
    output logic [21:0] closest_gain,
    output logic        found
);

    logic        va_reg, vb_reg, done_reg;
    logic [27:0] err_reg [NUM_RF][NUM_PGA];
    logic [27:0] row_err_reg [NUM_RF];
    logic [2:0]  row_j_reg [NUM_RF];
    logic [27:0] row_err_next [NUM_RF];
    logic [2:0]  row_j_next [NUM_RF];
    logic [2:0]  rf_reg, rf_next;
    logic [2:0]  pga_reg, pga_next;
    logic [21:0] gain_reg, gain_next;
    logic        found_reg, found_next;
    logic [27:0] best;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            done_reg <= vb_reg;
        end
    end

    for (genvar i = 0; i < NUM_RF; i++)
    begin : g_row
        for (genvar j = 0; j < NUM_PGA; j++)
        begin : g_col
            localparam logic [27:0] PQ4 = 28'(grs_prod(3'(i), 3'(j))) << 3;
            always_ff @(posedge clk)
            begin
                err_reg[i][j] <= (target > PQ4) ? target - PQ4 : PQ4 - target;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_RF; i++)
        begin
            row_err_next[i] = err_reg[i][0];
            row_j_next[i] = 3'd0;
            for (int j = 1; j < NUM_PGA; j++)
            begin
                if (err_reg[i][j] < row_err_next[i])
                begin
                    row_err_next[i] = err_reg[i][j];
                    row_j_next[i] = 3'(j);
                end
            end
        end
    end

    always_comb
    begin
        best = ERR_LIMIT;
        found_next = 1'b0;
        rf_next = 3'd0;
        pga_next = 3'd0;
        for (int i = 0; i < NUM_RF; i++)
        begin
            if (row_err_reg[i] < best)
            begin
                best = row_err_reg[i];
                found_next = 1'b1;
                rf_next = 3'(i);
                pga_next = row_j_reg[i];
            end
        end
        gain_next = found_next ? grs_prod(rf_next, pga_next) : 22'd0;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_RF; i++)
        begin
            row_err_reg[i] <= row_err_next[i];
            row_j_reg[i] <= row_j_next[i];
        end
        rf_reg <= rf_next;
        pga_reg <= pga_next;
        gain_reg <= gain_next;
        found_reg <= found_next;
    end

    assign done = done_reg;
    assign rf_index = rf_reg;
    assign pga_index = pga_reg;
    assign closest_gain = gain_reg;
    assign found = found_reg;

endmodule

FILE: design/gain_range_selector_top.sv
// Gain range selector. A frequency is taken when start is high and busy is low, one per clock
// at most, and its result appears with done high for one cycle; the receiver
// cannot stall, so every result must be captured in the cycle that done marks. The latency
// is set by the 16-step squaring logarithm, the 16-step root-product exponential and the
// three-stage compare tree. After reset and after every configuration write, busy stays high
// while one shared squaring unit recomputes the logarithms of the reference
// frequency and both gain registers.
module gain_range_selector_top
    import grs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [26:0] freq_mhz,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [2:0]  rf_index,
    output logic [2:0]  pga_index,
    output logic [21:0] closest_gain,
    output logic        found
);

    cfg_log_t    cfg_log;
    logic        accept;
    logic        lf_valid;
    logic [20:0] lf;
    logic        tgt_valid;
    logic [27:0] target;

    assign accept = start && !busy;

    grs_cfg_log u_cfg_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cfg_log   (cfg_log)
    );

    grs_log_pipe u_log_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .freq_mhz  (freq_mhz),
        .out_valid (lf_valid),
        .lf        (lf)
    );

    grs_exp_pipe u_exp_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lf_valid),
        .lf        (lf),
        .cfg_log   (cfg_log),
        .out_valid (tgt_valid),
        .target    (target)
    );

    grs_select u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (tgt_valid),
        .target       (target),
        .done         (done),
        .rf_index     (rf_index),
        .pga_index    (pga_index),
        .closest_gain (closest_gain),
        .found        (found)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##TOTAL_LAT done)
        else $error("accepted transfer did not complete at the fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, TOTAL_LAT))
        else $error("result without a matching accepted transfer");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (rf_index == 3'd0 && pga_index == 3'd0 && closest_gain == 22'd0))
        else $error("result fields not cleared when nothing was found");

    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("busy not raised after a configuration write");

endmodule

FILE: bench/gain_range_selector_top_test.sv
module gain_range_selector_top_test;
    import grs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  rf;
        logic [2:0]  pga;
        logic [21:0] gain;
        logic        fnd;
    } choice_t;

    typedef struct {
        logic [31:0] cmax;
        logic [31:0] cmin;
        logic [26:0] freq;
        bit          typed;
        choice_t     want;
    } row_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT = TOTAL_LAT + 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [26:0] freq_mhz = 27'd1;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_CG_MAX;
    logic [31:0] cfg_data = 32'd0;
    logic        done;
    logic [2:0]  rf_index;
    logic [2:0]  pga_index;
    logic [21:0] closest_gain;
    logic        found;

    logic [31:0] gain_hi = 32'd160000;
    logic [31:0] gain_lo = 32'd200;
    logic [63:0] roots [16];
    choice_t     pending [$];
    int          errors = 0;
    int          cycles = 0;
    bit          idle_en = 1'b1;

    gain_range_selector_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .freq_mhz(freq_mhz),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
        .rf_index(rf_index), .pga_index(pga_index), .closest_gain(closest_gain),
        .found(found)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v = v_in;
        res = 64'd0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 64'd0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] log2_q16(input logic [31:0] x_in);
        logic [31:0] x;
        logic [63:0] m;
        logic [31:0] fr;
        int          n;
        x = (x_in == 32'd0) ? 32'd1 : x_in;
        n = 31;
        while (!x[n])
        begin
            n--;
        end
        m = (n <= 30) ? (64'(x) << (30 - n)) : (64'(x) >> 1);
        fr = 32'd0;
        for (int k = 0; k < 16; k++)
        begin
            m = (m * m) >> 30;
            fr = {fr[30:0], 1'b0};
            if (m >= (64'd1 << 31))
            begin
                fr[0] = 1'b1;
                m = m >> 1;
            end
        end
        return 32'(n) * 32'd65536 + fr;
    endfunction

    function automatic logic [31:0] exp2_q4(input longint x);
        logic [15:0] fr;
        longint      ip;
        longint      r;
        logic [63:0] m;
        fr = x[15:0];
        ip = x >>> 16;
        m = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
        begin
            if (fr[16 - k])
            begin
                m = (m * roots[k - 1] + (64'd1 << 29)) >> 30;
            end
        end
        if (ip >= 24)
        begin
            return 32'(TARGET_MAX);
        end
        r = 26 - ip;
        if (r > 31)
        begin
            return 32'd0;
        end
        return 32'((m + (64'd1 << (r - 1))) >> r);
    endfunction

    function automatic choice_t predict_choice(input logic [26:0] f);
        longint      lmax;
        longint      lmin;
        longint      t;
        longint      p;
        longint      q;
        longint      den;
        logic [31:0] target;
        logic [31:0] best;
        logic [31:0] pq4;
        logic [31:0] err;
        logic [31:0] prod;
        choice_t     c;
        lmax = longint'(log2_q16(gain_hi));
        lmin = longint'(log2_q16(gain_lo));
        t = longint'(log2_q16(32'(f))) - longint'(log2_q16(32'd1000)) + 65536;
        p = (lmin - lmax) * t;
        den = 6 * 65536;
        if (p >= 0)
        begin
            q = (p + den / 2) / den;
        end
        else
        begin
            q = -((-p + den / 2) / den);
        end
        target = exp2_q4(lmax + q);
        best = 32'(ERR_LIMIT);
        c = '0;
        for (int i = 0; i < NUM_RF; i++)
        begin
            for (int j = 0; j < NUM_PGA; j++)
            begin
                prod = 32'(RF_OHMS[i]) * 32'(PGA_HALVES[j]);
                pq4 = prod * 32'd8;
                err = (target > pq4) ? target - pq4 : pq4 - target;
                if (err < best)
                begin
                    best = err;
                    c.rf = 3'(i);
                    c.pga = 3'(j);
                    c.gain = 22'(prod);
                    c.fnd = 1'b1;
                end
            end
        end
        return c;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        choice_t w;
        if (rst_n && start && !busy)
        begin
            pending.push_back(predict_choice(freq_mhz));
        end
        if (rst_n && done)
        begin
            if (pending.size() == 0)
            begin
                report("unexpected transfer", 1, 0);
            end
            else
            begin
                w = pending.pop_front();
                if (rf_index != w.rf) report("rf_index", rf_index, w.rf);
                if (pga_index != w.pga) report("pga_index", pga_index, w.pga);
                if (closest_gain != w.gain) report("closest_gain", closest_gain, w.gain);
                if (found != w.fnd) report("found", found, w.fnd);
            end
        end
    end

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_gains(input logic [31:0] hi, input logic [31:0] lo);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= CFG_CG_MAX;
        cfg_data <= hi;
        gain_hi = hi;
        @(negedge clk);
        cfg_index <= CFG_CG_MIN;
        cfg_data <= lo;
        gain_lo = lo;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_data <= $urandom;
    endtask

    task automatic send_freq(input logic [26:0] f);
        start <= 1'b1;
        freq_mhz <= f;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            freq_mhz <= 27'($urandom);
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] spread_word(input int bits);
        logic [31:0] v;
        v = $urandom;
        if (bits < 32)
        begin
            v = v & ((32'd1 << bits) - 32'd1);
        end
        return (v == 32'd0) ? 32'd1 : v;
    endfunction

    row_t rows [$];

    initial
    begin
        logic [63:0] c;
        logic [26:0] f;
        c = 64'd1 << 31;
        for (int k = 0; k < 16; k++)
        begin
            c = int_sqrt(c << 30);
            roots[k] = c;
        end

        rows.push_back('{32'd160000, 32'd200, 27'd100, 0, '0});
        rows.push_back('{32'd160000, 32'd200, 27'd1, 0, '0});
        rows.push_back('{32'd160000, 32'd200, 27'h7FFFFFF, 0, '0});
        rows.push_back('{32'd160000, 32'd200, 27'd100000000, 0, '0});
        rows.push_back('{32'd160000, 32'd200, 27'd1000, 0, '0});
        rows.push_back('{32'd160000, 32'd200, 27'h5555555, 0, '0});
        rows.push_back('{32'd160000, 32'd200, 27'h2AAAAAA, 0, '0});
        rows.push_back('{32'd1, 32'd1, 27'd1, 1, '{3'd0, 3'd0, 22'd400, 1'b1}});
        rows.push_back('{32'd1, 32'd1, 27'h7FFFFFF, 1, '{3'd0, 3'd0, 22'd400, 1'b1}});
        rows.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 27'd1, 1, '0});
        rows.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 27'h7FFFFFF, 1, '0});
        rows.push_back('{32'h1, 32'hFFFFFFFF, 27'd1, 0, '0});
        rows.push_back('{32'h1, 32'hFFFFFFFF, 27'd100, 0, '0});
        rows.push_back('{32'h1, 32'hFFFFFFFF, 27'h7FFFFFF, 0, '0});
        rows.push_back('{32'hFFFFFFFF, 32'h1, 27'd1, 0, '0});
        rows.push_back('{32'hFFFFFFFF, 32'h1, 27'd100000000, 0, '0});
        rows.push_back('{32'hFFFFFFFF, 32'h1, 27'h7FFFFFF, 0, '0});
        rows.push_back('{32'd2880000, 32'd400, 27'd100, 0, '0});
        rows.push_back('{32'd2880000, 32'd400, 27'd100000000, 0, '0});
        rows.push_back('{32'd2880000, 32'd400, 27'd3162, 0, '0});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].cmax != gain_hi || rows[i].cmin != gain_lo)
            begin
                set_gains(rows[i].cmax, rows[i].cmin);
            end
            if (rows[i].typed && predict_choice(rows[i].freq) != rows[i].want)
            begin
                report("typed expectation", predict_choice(rows[i].freq), rows[i].want);
            end
            send_freq(rows[i].freq);
        end

        for (int i = 0; i < 850; i++)
        begin
            idle_en = (i < 720);
            if (i % 100 == 0)
            begin
                set_gains(spread_word($urandom_range(1, 32)), spread_word($urandom_range(1, 32)));
            end
            f = 27'(spread_word($urandom_range(1, 27)));
            send_freq(f);
        end

        wait_drained();
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
